// ===== rtl/core/tbs_pkg.sv =====
// Shared types, constants and decode functions for the texture brush stamp.
// No dependencies; used by every module of the block.
`default_nettype none

package tbs_pkg;

  localparam int unsigned ADDR_W     = 12;
  localparam int unsigned VALUE_W    = 16;
  localparam int unsigned COORD_W    = 6;
  localparam int unsigned ROW_LEN_W  = 7;
  localparam int unsigned LIMIT_W    = 6;
  localparam int unsigned CFG_W      = 7;
  localparam int unsigned NUM_GROUPS = 5;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Configuration register indexes.
  localparam logic CFG_ROW_LENGTH    = 1'b0;
  localparam logic CFG_TOP_ROW_LIMIT = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [ROW_LEN_W-1:0] ROW_LENGTH_RST    = 7'd32;
  localparam logic [LIMIT_W-1:0]   TOP_ROW_LIMIT_RST = 6'd31;

  // Brush size codes.
  localparam logic [1:0] BRUSH_NONE  = 2'd0;
  localparam logic [1:0] BRUSH_ONE   = 2'd1;
  localparam logic [1:0] BRUSH_THREE = 2'd2;
  localparam logic [1:0] BRUSH_FIVE  = 2'd3;

  // Row groups of a footprint, in the order they are written.
  localparam logic [2:0] GRP_CENTER = 3'd0;
  localparam logic [2:0] GRP_UP1    = 3'd1;
  localparam logic [2:0] GRP_DOWN1  = 3'd2;
  localparam logic [2:0] GRP_UP2    = 3'd3;
  localparam logic [2:0] GRP_DOWN2  = 3'd4;

  typedef struct packed {
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_z;
    logic [1:0]         brush_size;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
  } stamp_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  texel_address;
    logic [VALUE_W-1:0] texel_value;
    logic               last_write;
  } texel_wr_t;

  // Classified stamp, handed from the front end to the write sequencer.
  typedef struct packed {
    logic [ADDR_W-1:0]     base;
    logic [VALUE_W-1:0]    value;
    logic [1:0]            size;
    logic [1:0]            reach_r;
    logic [1:0]            reach_l;
    logic [NUM_GROUPS-1:0] grp_en;
  } stamp_desc_t;

  // Column offset selected for one write: plus or minus the right or left
  // reach, or half of it, or nothing.
  typedef enum logic [3:0] {
    COL_ZERO    = 4'd0,
    COL_PR      = 4'd1,
    COL_PR_HALF = 4'd2,
    COL_NR      = 4'd3,
    COL_NR_HALF = 4'd4,
    COL_PL      = 4'd5,
    COL_PL_HALF = 4'd6,
    COL_NL      = 4'd7,
    COL_NL_HALF = 4'd8
  } col_sel_e;

  function automatic logic [2:0] group_len(input logic [1:0] size);
    logic [2:0] len;
    unique case (size)
      BRUSH_FIVE:  len = 3'd5;
      BRUSH_THREE: len = 3'd3;
      default:     len = 3'd1;
    endcase
    return len;
  endfunction

  function automatic col_sel_e col_sel(input logic [1:0] size, input logic [2:0] grp,
                                       input logic [2:0] col);
    col_sel_e sel;
    sel = COL_ZERO;
    if (size == BRUSH_FIVE) begin
      unique case (grp)
        GRP_CENTER: begin
          unique case (col)
            3'd0:    sel = COL_PR_HALF;
            3'd2:    sel = COL_NL_HALF;
            3'd3:    sel = COL_PR;
            3'd4:    sel = COL_NL;
            default: sel = COL_ZERO;
          endcase
        end
        GRP_UP1: begin
          unique case (col)
            3'd0:    sel = COL_NL;
            3'd1:    sel = COL_NL_HALF;
            3'd3:    sel = COL_PR_HALF;
            3'd4:    sel = COL_PR;
            default: sel = COL_ZERO;
          endcase
        end
        GRP_UP2: begin
          unique case (col)
            3'd0:    sel = COL_NL_HALF;
            3'd1:    sel = COL_NL;
            3'd3:    sel = COL_PR;
            3'd4:    sel = COL_PR_HALF;
            default: sel = COL_ZERO;
          endcase
        end
        default: begin
          // Both lower rows share one column order.
          unique case (col)
            3'd0:    sel = COL_PL_HALF;
            3'd1:    sel = COL_PL;
            3'd3:    sel = COL_NR;
            3'd4:    sel = COL_NR_HALF;
            default: sel = COL_ZERO;
          endcase
        end
      endcase
    end else if (size == BRUSH_THREE) begin
      unique case (grp)
        GRP_CENTER: begin
          unique case (col)
            3'd0:    sel = COL_PR;
            3'd2:    sel = COL_NL;
            default: sel = COL_ZERO;
          endcase
        end
        GRP_UP1: begin
          unique case (col)
            3'd0:    sel = COL_NL;
            3'd2:    sel = COL_PR;
            default: sel = COL_ZERO;
          endcase
        end
        default: begin
          unique case (col)
            3'd0:    sel = COL_PL;
            3'd2:    sel = COL_NR;
            default: sel = COL_ZERO;
          endcase
        end
      endcase
    end
    return sel;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tbs_front.sv =====
// Front end of the texture brush stamp: accepts stamp requests and classifies
// them into a descriptor for the write sequencer. Depends on tbs_pkg.
`default_nettype none

module tbs_front (
  input  var tbs_pkg::stamp_req_t                   stamp_i,
  input  var logic                                  start_i,
  input  var logic                                  queue_full_i,
  input  var logic [tbs_pkg::ROW_LEN_W-1:0]         row_length_i,
  input  var logic [tbs_pkg::LIMIT_W-1:0]           top_row_limit_i,
  output logic                                      push_o,
  output tbs_pkg::stamp_desc_t                      desc_o
);

  logic [13:0] prod;
  logic [6:0]  z_plus1;
  logic [6:0]  z_plus2;
  logic [6:0]  z_plus3;
  logic [7:0]  x_ext;
  logic [7:0]  rl_m1;
  logic [7:0]  rl_m2;
  logic        up1;
  logic        up2;
  logic        down;
  logic [1:0]  reach_r;
  logic [1:0]  reach_l;
  logic [1:0]  reach_3;

  always_comb begin
    z_plus1 = {1'b0, stamp_i.cell_z} + 7'd1;
    z_plus2 = {1'b0, stamp_i.cell_z} + 7'd2;
    z_plus3 = {1'b0, stamp_i.cell_z} + 7'd3;
    prod    = {7'b0, row_length_i} * {7'b0, z_plus1};

    up1  = z_plus2 <= {1'b0, top_row_limit_i};
    up2  = z_plus3 <= {1'b0, top_row_limit_i};
    down = stamp_i.cell_z >= 6'd2;

    // Edge tests; length below two wraps rl_m2, zero also rl_m1, above any column.
    x_ext = {2'b00, stamp_i.cell_x};
    rl_m1 = {1'b0, row_length_i} - 8'd1;
    rl_m2 = {1'b0, row_length_i} - 8'd2;

    if (x_ext == rl_m2) begin
      reach_r = 2'd1;
    end else if (x_ext == rl_m1) begin
      reach_r = 2'd0;
    end else begin
      reach_r = 2'd2;
    end

    if (stamp_i.cell_x == 6'd1) begin
      reach_l = 2'd1;
    end else if (stamp_i.cell_x == 6'd0) begin
      reach_l = 2'd0;
    end else begin
      reach_l = 2'd2;
    end

    reach_3 = ((x_ext == rl_m1) || (stamp_i.cell_x == 6'd0)) ? 2'd0 : 2'd1;

    desc_o.base  = prod[tbs_pkg::ADDR_W-1:0] - {6'b0, stamp_i.cell_x};
    desc_o.value = {stamp_i.red[7:3], stamp_i.green[7:3], stamp_i.blue[7:3],
                    stamp_i.alpha[0]};
    desc_o.size  = stamp_i.brush_size;

    unique case (stamp_i.brush_size)
      tbs_pkg::BRUSH_FIVE: begin
        desc_o.reach_r = reach_r;
        desc_o.reach_l = reach_l;
        desc_o.grp_en  = {down, up2, down, up1, 1'b1};
      end
      tbs_pkg::BRUSH_THREE: begin
        desc_o.reach_r = reach_3;
        desc_o.reach_l = reach_3;
        desc_o.grp_en  = {1'b0, 1'b0, down, up1, 1'b1};
      end
      default: begin
        desc_o.reach_r = 2'd0;
        desc_o.reach_l = 2'd0;
        desc_o.grp_en  = 5'b00001;
      end
    endcase

    // A stamp with no brush is taken and dropped here.
    push_o = start_i && !queue_full_i && (stamp_i.brush_size != tbs_pkg::BRUSH_NONE);
  end

endmodule

`default_nettype wire

// ===== rtl/core/tbs_queue.sv =====
// Short descriptor queue between the front end and the write sequencer.
// Depends on tbs_pkg.
`default_nettype none

module tbs_queue (
  input  var logic                  clk_i,
  input  var logic                  rst_ni,
  input  var logic                  push_i,
  input  var tbs_pkg::stamp_desc_t  desc_i,
  input  var logic                  pop_i,
  output tbs_pkg::stamp_desc_t      head_o,
  output logic                      empty_o,
  output logic                      full_o
);

  tbs_pkg::stamp_desc_t entry_q [tbs_pkg::QUEUE_DEPTH];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  always_comb begin
    empty_o  = count_q == 2'd0;
    full_o   = count_q == 2'(tbs_pkg::QUEUE_DEPTH);
    head_o   = entry_q[rd_ptr_q];
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= desc_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tbs_back.sv =====
// Write sequencer of the texture brush stamp: walks the row groups and
// columns of a footprint, one texel write per cycle. Depends on tbs_pkg.
`default_nettype none

module tbs_back (
  input  var logic                          clk_i,
  input  var logic                          rst_ni,
  input  var logic [tbs_pkg::ROW_LEN_W-1:0] row_length_i,
  input  var tbs_pkg::stamp_desc_t          head_i,
  input  var logic                          empty_i,
  output logic                              pop_o,
  output logic                              strobe_o,
  output tbs_pkg::texel_wr_t                texel_o
);

  tbs_pkg::stamp_desc_t cur_q;
  logic                 active_q;
  logic [2:0]           grp_q;
  logic [2:0]           col_q;
  logic                 strobe_q;
  tbs_pkg::texel_wr_t   texel_q;

  logic [2:0]                 len;
  logic                       col_last;
  logic                       has_next;
  logic [2:0]                 next_grp;
  logic                       last;
  logic                       finish;
  logic [tbs_pkg::ADDR_W-1:0] rl_ext;
  logic [tbs_pkg::ADDR_W-1:0] row_off;
  logic [tbs_pkg::ADDR_W-1:0] col_off;
  tbs_pkg::col_sel_e          sel;

  always_comb begin
    len      = tbs_pkg::group_len(cur_q.size);
    col_last = col_q == (len - 3'd1);

    // Lowest enabled group above the current one.
    has_next = 1'b0;
    next_grp = grp_q;
    for (int i = tbs_pkg::NUM_GROUPS - 1; i >= 0; i--) begin
      if (cur_q.grp_en[i] && (3'(i) > grp_q)) begin
        has_next = 1'b1;
        next_grp = 3'(i);
      end
    end

    last   = col_last && !has_next;
    finish = active_q && last;
    pop_o  = !empty_i && (!active_q || finish);

    rl_ext = {5'b0, row_length_i};
    unique case (grp_q)
      tbs_pkg::GRP_UP1:   row_off = rl_ext;
      tbs_pkg::GRP_DOWN1: row_off = -rl_ext;
      tbs_pkg::GRP_UP2:   row_off = rl_ext << 1;
      tbs_pkg::GRP_DOWN2: row_off = -(rl_ext << 1);
      default:            row_off = '0;
    endcase

    sel = tbs_pkg::col_sel(cur_q.size, grp_q, col_q);
    unique case (sel)
      tbs_pkg::COL_PR:      col_off = {10'b0, cur_q.reach_r};
      tbs_pkg::COL_PR_HALF: col_off = {11'b0, cur_q.reach_r[1]};
      tbs_pkg::COL_NR:      col_off = -{10'b0, cur_q.reach_r};
      tbs_pkg::COL_NR_HALF: col_off = -{11'b0, cur_q.reach_r[1]};
      tbs_pkg::COL_PL:      col_off = {10'b0, cur_q.reach_l};
      tbs_pkg::COL_PL_HALF: col_off = {11'b0, cur_q.reach_l[1]};
      tbs_pkg::COL_NL:      col_off = -{10'b0, cur_q.reach_l};
      tbs_pkg::COL_NL_HALF: col_off = -{11'b0, cur_q.reach_l[1]};
      default:              col_off = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      grp_q    <= tbs_pkg::GRP_CENTER;
      col_q    <= 3'd0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= active_q;
      if (pop_o) begin
        active_q <= 1'b1;
        grp_q    <= tbs_pkg::GRP_CENTER;
        col_q    <= 3'd0;
      end else if (finish) begin
        active_q <= 1'b0;
      end else if (active_q) begin
        if (col_last) begin
          grp_q <= next_grp;
          col_q <= 3'd0;
        end else begin
          col_q <= col_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
    texel_q.texel_address <= cur_q.base + row_off + col_off;
    texel_q.texel_value   <= cur_q.value;
    texel_q.last_write    <= last;
  end

  assign strobe_o = strobe_q;
  assign texel_o  = texel_q;

endmodule

`default_nettype wire

// ===== rtl/core/texture_brush_stamp.sv =====
// Top level of the texture brush stamp: configuration registers, front end,
// descriptor queue and write sequencer. Depends on tbs_pkg, tbs_front,
// tbs_queue and tbs_back.
//
// Usage. A stamp request word (stamp_i) is taken at a rising edge where
// start is high and busy is low. The block packs the color to RGBA5551 and
// emits the footprint's texel writes on texel_o, one word per cycle marked
// by result_strobe_o, with last_write set on the final write of the stamp.
// A request with brush size zero is taken and produces no writes.
//
// Throughput. When the sequencer is free, the first write of a taken
// request passes the queue, the sequencer registers and the output
// registers. The sequencer emits one write per cycle: one write for the
// single texel brush, three to nine for the three wide brush and five to
// 25 for the five wide brush, set by how many row groups fall inside the
// texture. Writes of consecutive stamps follow with no gap. A two-word
// queue sits between request intake and the sequencer, so busy rises only
// when two stamps wait behind the one in work. The receiver cannot stall:
// each write is shown for exactly one cycle. Reset clears the queue and
// the sequencer and sets row_length to 32 and top_row_limit to 31.
// Configuration is written through cfg_we_i, cfg_index_i and cfg_data_i;
// the user must write only while the block is idle; nothing enforces it.
`default_nettype none

module texture_brush_stamp (
  input  var logic                        clk_i,
  input  var logic                        rst_ni,
  input  var logic                        start,
  output logic                            busy,
  input  var tbs_pkg::stamp_req_t         stamp_i,
  output logic                            result_strobe_o,
  output tbs_pkg::texel_wr_t              texel_o,
  input  var logic                        cfg_we_i,
  input  var logic                        cfg_index_i,
  input  var logic [tbs_pkg::CFG_W-1:0]   cfg_data_i
);

  logic [tbs_pkg::ROW_LEN_W-1:0] row_length_q;
  logic [tbs_pkg::LIMIT_W-1:0]   top_row_limit_q;

  logic                 push;
  logic                 pop;
  logic                 q_empty;
  logic                 q_full;
  tbs_pkg::stamp_desc_t desc_in;
  tbs_pkg::stamp_desc_t desc_head;

  // Configuration registers, written without handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q    <= tbs_pkg::ROW_LENGTH_RST;
      top_row_limit_q <= tbs_pkg::TOP_ROW_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tbs_pkg::CFG_ROW_LENGTH:    row_length_q    <= cfg_data_i;
        tbs_pkg::CFG_TOP_ROW_LIMIT: top_row_limit_q <= cfg_data_i[tbs_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = q_full;

  tbs_front u_front (
    .stamp_i         (stamp_i),
    .start_i         (start),
    .queue_full_i    (q_full),
    .row_length_i    (row_length_q),
    .top_row_limit_i (top_row_limit_q),
    .push_o          (push),
    .desc_o          (desc_in)
  );

  tbs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (desc_in),
    .pop_i   (pop),
    .head_o  (desc_head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  tbs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .row_length_i (row_length_q),
    .head_i       (desc_head),
    .empty_i      (q_empty),
    .pop_o        (pop),
    .strobe_o     (result_strobe_o),
    .texel_o      (texel_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/tbs_checker.sv =====
// Port-level checks for the texture brush stamp, bound to the top level.
// Depends on tbs_pkg and texture_brush_stamp.
`default_nettype none

module tbs_checker (
  input var logic                clk_i,
  input var logic                rst_ni,
  input var logic                start,
  input var logic                busy,
  input var logic                result_strobe_o,
  input var tbs_pkg::texel_wr_t  texel_o
);

  // Writes of one stamp come out on consecutive cycles.
  a_writes_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && !texel_o.last_write |=> result_strobe_o)
    else $error("stamp writes were interrupted before the last write");

  // Every write of one stamp carries the same color.
  a_value_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && !texel_o.last_write |=> $stable(texel_o.texel_value))
    else $error("texel value changed within a stamp");

  // The queue only fills through a taken request.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy rose without a taken request");

endmodule

bind texture_brush_stamp tbs_checker u_tbs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .result_strobe_o (result_strobe_o),
  .texel_o         (texel_o)
);

`default_nettype wire
